// ===== src/periodic_task_release_scheduler_top_defines.svh =====
// Assertion macros for the periodic task release scheduler.
`ifndef PERIODIC_TASK_RELEASE_SCHEDULER_TOP_DEFINES_SVH
`define PERIODIC_TASK_RELEASE_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication
`define PTRS_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PTRS_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ptrs_pkg.sv =====
// Package: shared constants and entry layout for the task release scheduler.
package ptrs_pkg;
	localparam int TASK_COUNT = 16;
	localparam int IDX_W      = 4;
	localparam int PER_W      = 16;
	localparam int TICK_W     = 32;
	localparam int ENT_W      = PER_W + TICK_W;
	localparam int MASK_W     = 16;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_PROG = 1'b1;

	typedef struct packed {
		logic [PER_W-1:0]  period;
		logic [TICK_W-1:0] release_tick;
	} entry_t;
endpackage

// ===== src/periodic_task_release_scheduler_top.sv =====
// Top level: periodic task release scheduler with fixed-priority pick.
//
// Channel  Dir  Signals                        Contents
// s        in   s_tvalid s_tready s_tdata s_tuser  one command per transaction
// m        out  m_tvalid m_tready m_tdata m_tuser  one result per command
// cfg      in   cfg_valid cfg_ready cfg_data       task enable mask write
//
// A tick walks the states in order: a sweep that reads each task entry from the entry
// RAM in turn, a drain state for the last read, a final state that loads the result,
// and idle, where the next command is accepted. A program command goes from idle
// straight to the final state. One command is in flight.
// A full, stalled result register holds the command in its last cycle, s_tready low.
// Reset clears counter, ready mask, entry valid bits.
module periodic_task_release_scheduler_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,    // task_index[3:0], task_period[19:4], zero fill
	input  logic        s_tuser,    // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,    // picked_task[3:0], current_tick[35:4], ready_tasks[51:36], zero fill
	output logic        m_tuser,    // picked_valid
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data    // task_enable_mask
);
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	localparam int TC = ptrs_pkg::TASK_COUNT;
	localparam int IW = ptrs_pkg::IDX_W;

	logic [1:0]                  state_q;
	logic [ptrs_pkg::MASK_W-1:0] en_q;
	logic [ptrs_pkg::TICK_W-1:0] tick_q;
	logic [TC-1:0]               ready_q;
	logic [TC-1:0]               ent_valid_q;
	logic [IW-1:0]               k_q;
	logic                        sweep_s1;
	logic [IW-1:0]               idx_s1;
	logic                        ent_ok_s1;
	logic                        found_q;
	logic [IW-1:0]               pick_q;

	logic                        m_tvalid_q;
	logic                        o_valid_q;
	logic [IW-1:0]               o_task_q;
	logic [ptrs_pkg::TICK_W-1:0] o_tick_q;
	logic [ptrs_pkg::MASK_W-1:0] o_ready_q;

	logic                        in_acc;
	logic                        prog_acc;
	logic                        tick_acc;
	logic [IW-1:0]               in_idx;
	logic [ptrs_pkg::PER_W-1:0]  in_per;
	logic                        out_free;

	ptrs_pkg::entry_t            rd_ent;
	ptrs_pkg::entry_t            cur_ent;
	ptrs_pkg::entry_t            wr_ent;
	logic [ptrs_pkg::ENT_W-1:0]  rd_raw;
	logic                        rel_hit;
	logic                        bit_now;
	logic                        take;
	logic                        wr_en;
	logic [IW-1:0]               wr_addr;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign in_idx    = s_tdata[IW-1:0];
	assign in_per    = s_tdata[IW +: ptrs_pkg::PER_W];
	assign prog_acc  = in_acc && (s_tuser == ptrs_pkg::OP_PROG)
		&& ({1'b0, in_idx} < (IW+1)'(TC));
	assign tick_acc  = in_acc && (s_tuser == ptrs_pkg::OP_TICK);
	assign out_free  = !m_tvalid_q || m_tready;

	assign rd_ent  = ptrs_pkg::entry_t'(rd_raw);
	assign cur_ent = ent_ok_s1 ? rd_ent : '0;
	assign rel_hit = en_q[idx_s1] && !ready_q[idx_s1] && (tick_q >= cur_ent.release_tick);
	assign bit_now = ready_q[idx_s1] || rel_hit;
	assign take    = sweep_s1 && bit_now && !found_q;

	always_comb begin
		wr_en   = prog_acc || take;
		wr_addr = in_idx;
		wr_ent.period       = in_per;
		wr_ent.release_tick = ptrs_pkg::TICK_W'(in_per);
		if (take) begin
			wr_addr             = idx_s1;
			wr_ent.period       = cur_ent.period;
			wr_ent.release_tick = cur_ent.release_tick
				+ ptrs_pkg::TICK_W'(cur_ent.period);
		end
	end

	ptrs_ram #(
		.WIDTH  (ptrs_pkg::ENT_W),
		.DEPTH  (TC),
		.ADDR_W (IW)
	) u_ent_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_ent),
		.rd_addr (k_q),
		.rd_data (rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			en_q        <= '0;
			tick_q      <= '0;
			ready_q     <= '0;
			ent_valid_q <= '0;
			k_q         <= '0;
			sweep_s1    <= 1'b0;
			idx_s1      <= '0;
			ent_ok_s1   <= 1'b0;
			found_q     <= 1'b0;
			pick_q      <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				en_q <= cfg_data;
			end

			sweep_s1  <= (state_q == ST_SWEEP);
			idx_s1    <= k_q;
			ent_ok_s1 <= ent_valid_q[k_q];

			if (wr_en) begin
				ent_valid_q[wr_addr] <= 1'b1;
			end
			if (prog_acc) begin
				ready_q[in_idx] <= 1'b0;
			end
			if (sweep_s1) begin
				ready_q[idx_s1] <= bit_now && !take;
			end
			if (take) begin
				found_q <= 1'b1;
				pick_q  <= idx_s1;
			end

			if (state_q == ST_FIN && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						found_q <= 1'b0;
						pick_q  <= '0;
						k_q     <= '0;
						if (tick_acc) begin
							tick_q  <= tick_q + 1'b1;
							state_q <= ST_SWEEP;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_SWEEP: begin
					if (k_q == IW'(TC-1)) begin
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			o_valid_q <= found_q;
			o_task_q  <= pick_q;
			o_tick_q  <= tick_q;
			o_ready_q <= ptrs_pkg::MASK_W'(ready_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = o_valid_q;
	assign m_tdata  = {4'b0, o_ready_q, o_tick_q, o_task_q};

`include "periodic_task_release_scheduler_top_defines.svh"

	`PTRS_ASSERT_NOW(a_pick_not_ready, clk, arst_n, m_tvalid_q && o_valid_q, !o_ready_q[o_task_q], "picked task still ready")
	`PTRS_ASSERT_NEXT(a_prog_blocks, clk, arst_n, prog_acc, !ready_q[$past(in_idx)], "programmed task not blocked")
	`PTRS_ASSERT_NEXT(a_tick_adv, clk, arst_n, tick_acc, tick_q == $past(tick_q) + 1'b1, "tick counter did not advance")
endmodule

// ===== src/ptrs_ram.sv =====
// Generic single-port-write, registered-read RAM.
module ptrs_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the periodic task release scheduler.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int SETTLE_TICKS = 2 * (ptrs_pkg::TASK_COUNT + 3) + 8;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 200;

	typedef struct packed {
		logic                        opcode;
		logic [ptrs_pkg::IDX_W-1:0]  task_index;
		logic [ptrs_pkg::PER_W-1:0]  task_period;
	} sched_cmd_t;

	typedef struct packed {
		logic                        picked_valid;
		logic [ptrs_pkg::IDX_W-1:0]  picked_task;
		logic [ptrs_pkg::TICK_W-1:0] current_tick;
		logic [ptrs_pkg::MASK_W-1:0] ready_tasks;
	} sched_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	periodic_task_release_scheduler_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	// scheduler state as the block should hold it
	logic [ptrs_pkg::MASK_W-1:0] enable_mask = '0;
	logic [ptrs_pkg::TICK_W-1:0] tick_now = '0;
	logic [ptrs_pkg::MASK_W-1:0] ready_now = '0;
	logic [ptrs_pkg::PER_W-1:0]  period_tab [ptrs_pkg::TASK_COUNT];
	logic [ptrs_pkg::TICK_W-1:0] release_tab [ptrs_pkg::TASK_COUNT];

	sched_cmd_t    cmd_queue [$];
	sched_result_t expected_results [$];

	sched_cmd_t    seen_cmd;
	sched_cmd_t    next_cmd;
	sched_result_t want;
	logic          s_taken = 1'b0;
	logic          m_taken = 1'b0;
	int            s_gap = 0;
	int            s_calm = 0;
	int            m_stall = 0;
	int            m_calm = 0;
	int            errors = 0;
	int            cycles = 0;
	int            ticks_issued = 0;

	initial begin
		for (int k = 0; k < ptrs_pkg::TASK_COUNT; k++) begin
			period_tab[k] = '0;
			release_tab[k] = '0;
		end
	end

	function automatic sched_result_t release_and_pick(input sched_cmd_t c);
		sched_result_t r;
		r = '0;
		if (c.opcode == ptrs_pkg::OP_PROG) begin
			period_tab[c.task_index] = c.task_period;
			release_tab[c.task_index] = ptrs_pkg::TICK_W'(c.task_period);
			ready_now[c.task_index] = 1'b0;
		end else begin
			tick_now = tick_now + 1'b1;
			for (int k = 0; k < ptrs_pkg::TASK_COUNT; k++)
				if (enable_mask[k] && !ready_now[k] && tick_now >= release_tab[k])
					ready_now[k] = 1'b1;
			for (int k = 0; k < ptrs_pkg::TASK_COUNT; k++)
				if (ready_now[k] && !r.picked_valid) begin
					r.picked_valid = 1'b1;
					r.picked_task = ptrs_pkg::IDX_W'(k);
					ready_now[k] = 1'b0;
					release_tab[k] = release_tab[k] + ptrs_pkg::TICK_W'(period_tab[k]);
				end
		end
		r.current_tick = tick_now;
		r.ready_tasks = ready_now;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		errors++;
		if (errors <= 100)
			$display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, exp_val);
	endtask

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// monitor: input acceptance feeds the predictor, output transactions are checked
	always @(posedge clk) begin
		if (!arst_n) begin
			s_taken <= 1'b0;
			m_taken <= 1'b0;
		end else begin
			s_taken <= s_tvalid && s_tready;
			m_taken <= m_tvalid && m_tready;
			if (s_tvalid && s_tready) begin
				seen_cmd.opcode = s_tuser;
				seen_cmd.task_index = s_tdata[ptrs_pkg::IDX_W-1:0];
				seen_cmd.task_period =
					s_tdata[ptrs_pkg::IDX_W+ptrs_pkg::PER_W-1:ptrs_pkg::IDX_W];
				expected_results.push_back(release_and_pick(seen_cmd));
			end
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected transaction", m_tdata[31:0], '0);
				end else begin
					want = expected_results.pop_front();
					if (m_tuser !== want.picked_valid)
						report_mismatch("picked_valid", 32'(m_tuser),
							32'(want.picked_valid));
					if (m_tdata[ptrs_pkg::IDX_W-1:0] !== want.picked_task)
						report_mismatch("picked_task", 32'(m_tdata[ptrs_pkg::IDX_W-1:0]),
							32'(want.picked_task));
					if (m_tdata[ptrs_pkg::IDX_W+ptrs_pkg::TICK_W-1:ptrs_pkg::IDX_W]
							!== want.current_tick)
						report_mismatch("current_tick",
							m_tdata[ptrs_pkg::IDX_W+ptrs_pkg::TICK_W-1:ptrs_pkg::IDX_W],
							want.current_tick);
					if (m_tdata[51:36] !== want.ready_tasks)
						report_mismatch("ready_tasks", 32'(m_tdata[51:36]),
							32'(want.ready_tasks));
				end
			end
		end
	end

	// command driver
	always @(negedge clk) begin
		if (arst_n && (s_taken || !s_tvalid)) begin
			if (s_gap > 0) begin
				s_gap--;
				s_tvalid <= 1'b0;
			end else if (cmd_queue.size() > 0) begin
				next_cmd = cmd_queue.pop_front();
				s_tuser <= next_cmd.opcode;
				s_tdata <= {4'b0, next_cmd.task_period, next_cmd.task_index};
				s_tvalid <= 1'b1;
				if (s_calm > 0) begin
					s_calm--;
					s_gap = 0;
				end else begin
					s_gap = idle_len();
					if ($urandom_range(0, 47) == 0)
						s_calm = $urandom_range(20, 80);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result receiver with random back-pressure
	always @(negedge clk) begin
		if (m_taken) begin
			if (m_calm > 0) begin
				m_calm--;
				m_stall = 0;
			end else begin
				m_stall = idle_len();
				if ($urandom_range(0, 47) == 0)
					m_calm = $urandom_range(20, 80);
			end
		end
		if (m_stall > 0) begin
			m_stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic add_tick();
		sched_cmd_t c;
		c.opcode = ptrs_pkg::OP_TICK;
		c.task_index = ptrs_pkg::IDX_W'($urandom_range(0, 15));
		c.task_period = ptrs_pkg::PER_W'($urandom_range(0, 65535));
		cmd_queue.push_back(c);
		ticks_issued++;
	endtask

	task automatic add_program(input int idx, input int per);
		sched_cmd_t c;
		c.opcode = ptrs_pkg::OP_PROG;
		c.task_index = ptrs_pkg::IDX_W'(idx);
		c.task_period = ptrs_pkg::PER_W'(per);
		cmd_queue.push_back(c);
	endtask

	// mostly short periods so releases keep happening; some land just ahead of the counter
	function automatic int pick_period();
		int r;
		int p;
		r = $urandom_range(0, 99);
		if (r < 30)
			return $urandom_range(0, 8);
		if (r < 60)
			return $urandom_range(9, 40);
		if (r < 85) begin
			p = ticks_issued + $urandom_range(0, 30);
			return (p > 65535) ? 65535 : p;
		end
		if (r < 95)
			return $urandom_range(41, 400);
		return $urandom_range(0, 65535);
	endfunction

	task automatic wait_idle();
		while (cmd_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_enable(input logic [15:0] mask);
		@(negedge clk);
		cfg_data <= mask;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		enable_mask = mask;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input int budget);
		int n;
		int runs;
		n = 0;
		while (n < budget) begin
			if ($urandom_range(0, 99) < 85) begin
				runs = $urandom_range(1, 4);
				for (int k = 0; k < runs; k++) begin
					add_program($urandom_range(0, 15), pick_period());
					n++;
				end
				runs = $urandom_range(4, 40);
				for (int k = 0; k < runs; k++) begin
					add_tick();
					n++;
				end
			end else begin
				runs = $urandom_range(1, 8);
				for (int k = 0; k < runs; k++) begin
					if ($urandom_range(0, 1))
						add_tick();
					else
						add_program($urandom_range(0, 15), $urandom_range(0, 65535));
					n++;
				end
			end
		end
	endtask

	function automatic logic [15:0] phase_mask(input int p);
		case (p)
			0, 4:    return 16'hFFFF;
			1:       return 16'h0001;
			2:       return 16'h8000;
			5:       return 16'h00FF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all disabled after reset: nothing may be released
		add_tick();
		add_tick();
		wait_idle();
		write_enable(16'hFFFF);
		// every task released at once, lowest index wins
		add_tick();
		add_program(0, 0);
		add_program(15, 65535);
		add_program(5, 16'hAAAA);
		add_program(6, 16'h5555);
		add_program(3, 3);
		for (int k = 0; k < 12; k++)
			add_tick();
		// reprogramming a ready task blocks it again
		add_program(9, 1);
		for (int k = 0; k < 3; k++)
			add_tick();
		wait_idle();
		// tasks left ready keep being picked after disable
		write_enable(16'h0000);
		for (int k = 0; k < 4; k++)
			add_tick();

		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			write_enable(phase_mask(p));
			run_random(PHASE_ITEMS);
		end

		wait_idle();
		repeat (SETTLE_TICKS) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

// ===== periodic_task_release_scheduler_top.f =====
+incdir+src
src/ptrs_pkg.sv
src/ptrs_ram.sv
src/periodic_task_release_scheduler_top.sv
tb/tb.sv
